@@ rtl/psds_pkg.sv @@
// shared types and constants of the parity split dual stack
// no dependencies

package psds_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef logic signed [ValueWidth-1:0] value_t;

  localparam value_t EmptyValue = '1;

endpackage

@@ rtl/parity_split_dual_stack_unit.sv @@
// Two bounded LIFO stacks of signed 32-bit values split by parity. On each transfer a
// push or pop is decided from the two cached stack tops and the counters, and the
// result lands in the output register at the transfer edge, so one operation per cycle
// is sustained while the output side keeps tready high. Each stack lives in its own
// memory with one write port and one registered read port; a pop fetches the entry
// below the popped one so the new top is ready next cycle.
// Input tuser carries the opcode (0 push, 1 pop); stack contents are undefined
// until written, counters reset to zero.
// depends on psds_pkg

module parity_split_dual_stack_unit #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] push_value
  input  logic [0:0]  s_axis_tuser_i,   // [0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] result_value
  output logic [2:0]  m_axis_tuser_o    // [1:0] status, [2] from_odd
);

  localparam int unsigned CntWidth  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrWidth = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(STACK_DEPTH);
  localparam logic [CntWidth-1:0] CntOne  = CntWidth'(1);
  localparam logic [CntWidth-1:0] CntTwo  = CntWidth'(2);

  // stack memories
  psds_pkg::value_t even_mem [STACK_DEPTH];
  psds_pkg::value_t odd_mem  [STACK_DEPTH];

  logic [CntWidth-1:0] even_cnt_q, even_cnt_d;
  logic [CntWidth-1:0] odd_cnt_q, odd_cnt_d;
  psds_pkg::value_t    even_top_q, odd_top_q;
  psds_pkg::value_t    even_rd_q, odd_rd_q;
  logic                even_from_mem_q, even_from_mem_d;
  logic                odd_from_mem_q, odd_from_mem_d;

  logic                  out_valid_q;
  psds_pkg::value_t      out_value_q, out_value_d;
  psds_pkg::status_e     out_status_q, out_status_d;
  logic                  out_odd_q, out_odd_d;

  logic              in_xfer;
  psds_pkg::value_t  push_value;
  psds_pkg::opcode_e opcode;
  psds_pkg::value_t  even_top, odd_top;
  logic              have_even, have_odd, take_even;
  logic              push_even, push_odd, pop_even, pop_odd;
  logic [CntWidth-1:0] even_below, odd_below;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign push_value      = s_axis_tdata_i;
  assign opcode          = psds_pkg::opcode_e'(s_axis_tuser_i[0]);

  assign even_top  = even_from_mem_q ? even_rd_q : even_top_q;
  assign odd_top   = odd_from_mem_q ? odd_rd_q : odd_top_q;
  assign have_even = even_cnt_q != '0;
  assign have_odd  = odd_cnt_q != '0;
  assign take_even = have_even && (!have_odd || (even_top > odd_top));
  assign even_below = even_cnt_q - CntTwo;
  assign odd_below  = odd_cnt_q - CntTwo;

  always_comb begin
    push_even    = 1'b0;
    push_odd     = 1'b0;
    pop_even     = 1'b0;
    pop_odd      = 1'b0;
    out_value_d  = '0;
    out_status_d = psds_pkg::ST_OK;
    out_odd_d    = 1'b0;
    case (opcode)
      psds_pkg::OP_PUSH: begin
        out_odd_d = push_value[0];
        if (push_value[0]) begin
          if (odd_cnt_q == CntFull) out_status_d = psds_pkg::ST_FULL;
          else                      push_odd     = in_xfer;
        end else begin
          if (even_cnt_q == CntFull) out_status_d = psds_pkg::ST_FULL;
          else                       push_even    = in_xfer;
        end
      end
      psds_pkg::OP_POP: begin
        if (!have_even && !have_odd) begin
          out_value_d  = psds_pkg::EmptyValue;
          out_status_d = psds_pkg::ST_EMPTY;
        end else if (take_even) begin
          out_value_d = even_top;
          pop_even    = in_xfer;
        end else begin
          out_value_d = odd_top;
          out_odd_d   = 1'b1;
          pop_odd     = in_xfer;
        end
      end
      default: ;
    endcase

    even_cnt_d      = even_cnt_q;
    odd_cnt_d       = odd_cnt_q;
    even_from_mem_d = even_from_mem_q;
    odd_from_mem_d  = odd_from_mem_q;
    if (push_even) begin
      even_cnt_d      = even_cnt_q + CntOne;
      even_from_mem_d = 1'b0;
    end
    if (pop_even) begin
      even_cnt_d      = even_cnt_q - CntOne;
      even_from_mem_d = 1'b1;
    end
    if (push_odd) begin
      odd_cnt_d      = odd_cnt_q + CntOne;
      odd_from_mem_d = 1'b0;
    end
    if (pop_odd) begin
      odd_cnt_d      = odd_cnt_q - CntOne;
      odd_from_mem_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_cnt_q      <= '0;
      odd_cnt_q       <= '0;
      even_from_mem_q <= 1'b0;
      odd_from_mem_q  <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      even_cnt_q      <= even_cnt_d;
      odd_cnt_q       <= odd_cnt_d;
      even_from_mem_q <= even_from_mem_d;
      odd_from_mem_q  <= odd_from_mem_d;
      if (s_axis_tready_o) out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_odd_q    <= out_odd_d;
    end
    if (push_even) even_top_q <= push_value;
    if (push_odd)  odd_top_q  <= push_value;
  end

  // even stack memory
  always_ff @(posedge clk_i) begin
    if (push_even) even_mem[even_cnt_q[AddrWidth-1:0]] <= push_value;
    if (pop_even)  even_rd_q <= even_mem[even_below[AddrWidth-1:0]];
  end

  // odd stack memory
  always_ff @(posedge clk_i) begin
    if (push_odd) odd_mem[odd_cnt_q[AddrWidth-1:0]] <= push_value;
    if (pop_odd)  odd_rd_q <= odd_mem[odd_below[AddrWidth-1:0]];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = {out_odd_q, out_status_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (even_cnt_q <= CntFull) && (odd_cnt_q <= CntFull))
    else $error("stack count beyond depth");

  a_empty_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == psds_pkg::ST_EMPTY) |->
      (out_value_q == psds_pkg::EmptyValue && !out_odd_q))
    else $error("empty pop without all-ones result");

  a_odd_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_odd |=> (odd_cnt_q == $past(odd_cnt_q) + CntOne) && !odd_from_mem_q)
    else $error("odd push did not advance the stack");

  a_pop_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_even && pop_odd) && !(push_even && push_odd))
    else $error("both stacks touched in one transfer");

endmodule

@@ tb/sv/tb.sv @@
// self-checking bench for parity_split_dual_stack_unit: directed and random push/pop
// streams, both sides idling, checked against in-bench models of the parity stacks
// depends on psds_pkg and the rtl of parity_split_dual_stack_unit
`timescale 1ns / 100ps

module tb;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned NumItems    = 1650;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned TailCycles  = 20;

  typedef struct packed {
    logic              pause;
    psds_pkg::opcode_e op;
    psds_pkg::value_t  val;
  } stack_req_t;

  typedef struct packed {
    psds_pkg::value_t  value;
    psds_pkg::status_e status;
    logic              odd;
  } stack_resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_data = '0;
  logic [0:0]  in_user = psds_pkg::OP_PUSH;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_data;
  logic [2:0]  out_user;

  stack_req_t  op_queue[$];
  stack_resp_t pending_results[$];

  psds_pkg::value_t even_model[STACK_DEPTH];
  psds_pkg::value_t odd_model[STACK_DEPTH];
  int unsigned even_depth = 0;
  int unsigned odd_depth = 0;

  int unsigned items_queued = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned stall_cycles = 0;

  parity_split_dual_stack_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_data),
    .s_axis_tuser_i (in_user),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_data),
    .m_axis_tuser_o (out_user)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // push by parity or pop the larger top, odd top taken on a tie
  function automatic stack_resp_t apply_stack_op(psds_pkg::opcode_e op, psds_pkg::value_t v);
    stack_resp_t r;
    logic take_even;
    r.value  = '0;
    r.status = psds_pkg::ST_OK;
    r.odd    = 1'b0;
    if (op == psds_pkg::OP_PUSH) begin
      r.odd = v[0];
      if (v[0]) begin
        if (odd_depth < STACK_DEPTH) begin
          odd_model[odd_depth] = v;
          odd_depth++;
        end else begin
          r.status = psds_pkg::ST_FULL;
        end
      end else begin
        if (even_depth < STACK_DEPTH) begin
          even_model[even_depth] = v;
          even_depth++;
        end else begin
          r.status = psds_pkg::ST_FULL;
        end
      end
    end else if (even_depth == 0 && odd_depth == 0) begin
      r.value  = psds_pkg::EmptyValue;
      r.status = psds_pkg::ST_EMPTY;
    end else begin
      take_even = (odd_depth == 0) ||
                  (even_depth != 0 && even_model[even_depth-1] > odd_model[odd_depth-1]);
      if (take_even) begin
        even_depth--;
        r.value = even_model[even_depth];
      end else begin
        odd_depth--;
        r.value = odd_model[odd_depth];
        r.odd   = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void add_item(logic pause, psds_pkg::opcode_e op, psds_pkg::value_t v);
    stack_req_t q;
    q.pause = pause;
    q.op    = op;
    q.val   = v;
    op_queue.push_back(q);
    if (!pause) items_queued++;
  endfunction

  function automatic psds_pkg::value_t rand_value();
    psds_pkg::value_t v;
    case ($urandom_range(0, 3))
      0, 1: v = $urandom;
      2: v = $signed($urandom_range(0, 16)) - 8;
      default: begin
        case ($urandom_range(0, 5))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 0;
          3: v = -1;
          4: v = 1;
          default: v = -2;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic flag_error(string msg);
    if (error_count < 10) $display("mismatch: %s", msg);
    error_count++;
  endtask

  initial begin : stimulus_proc
    int unsigned seg;
    int unsigned n;
    logic par;
    psds_pkg::value_t v;
    // directed: empty pop, single-stack pops, negative parity, extremes
    add_item(1'b0, psds_pkg::OP_POP, 32'sh1234_5678);
    add_item(1'b0, psds_pkg::OP_PUSH, -3);
    add_item(1'b0, psds_pkg::OP_POP, 0);
    add_item(1'b0, psds_pkg::OP_PUSH, -4);
    add_item(1'b0, psds_pkg::OP_POP, -1);
    add_item(1'b0, psds_pkg::OP_PUSH, 32'sh7fff_ffff);
    add_item(1'b0, psds_pkg::OP_PUSH, 32'sh8000_0000);
    add_item(1'b0, psds_pkg::OP_PUSH, 0);
    add_item(1'b0, psds_pkg::OP_PUSH, -1);
    add_item(1'b0, psds_pkg::OP_PUSH, 1);
    add_item(1'b0, psds_pkg::OP_PUSH, 2);
    repeat (6) add_item(1'b0, psds_pkg::OP_POP, $urandom);
    add_item(1'b0, psds_pkg::OP_POP, 32'shffff_ffff);
    add_item(1'b1, psds_pkg::OP_PUSH, 0);
    while (items_queued < NumItems) begin
      seg = $urandom_range(0, 15);
      if (seg == 15) begin
        if (items_queued > 400) add_item(1'b1, psds_pkg::OP_PUSH, 0);
      end else if (seg < 5) begin
        // run of same-parity pushes, usually hits the full limit
        par = $urandom_range(0, 1);
        n = $urandom_range(20, 40);
        repeat (n) begin
          v = rand_value();
          v[0] = par;
          add_item(1'b0, psds_pkg::OP_PUSH, v);
        end
      end else if (seg < 8) begin
        n = $urandom_range(8, 40);
        repeat (n) add_item(1'b0, psds_pkg::OP_POP, $urandom);
      end else if (seg < 14) begin
        n = $urandom_range(4, 30);
        repeat (n) begin
          if ($urandom_range(0, 99) < 55) add_item(1'b0, psds_pkg::OP_PUSH, rand_value());
          else add_item(1'b0, psds_pkg::OP_POP, $urandom);
        end
      end else begin
        n = $urandom_range(2, 10);
        repeat (n) add_item(1'b0, psds_pkg::opcode_e'($urandom_range(0, 1)), $urandom);
      end
    end
    do begin
      @(posedge clk_i);
    end while (op_queue.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    stack_req_t nxt;
    logic go;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_results.push_back(apply_stack_op(psds_pkg::opcode_e'(in_user[0]),
                                                 psds_pkg::value_t'(in_data)));
        items_sent <= items_sent + 1;
      end
      if (!in_valid || in_ready) begin
        // pause marker: hold off until every result is back
        if (op_queue.size() != 0 && op_queue[0].pause && pending_results.size() == 0) begin
          op_queue.delete(0);
        end
        go = (items_sent >= 600 && items_sent < 900) || $urandom_range(0, 99) >= 33;
        if (go && op_queue.size() != 0 && !op_queue[0].pause) begin
          nxt = op_queue.pop_front();
          in_valid <= 1'b1;
          in_data  <= nxt.val;
          in_user  <= nxt.op;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 200) begin
      out_ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
    end else begin
      out_ready <= (results_seen >= 600 && results_seen < 900) ||
                   $urandom_range(0, 99) >= 33;
    end
  end

  always @(posedge clk_i) begin : check_proc
    stack_resp_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result with none expected: value %0d status %0d from_odd %0b",
                             $signed(out_data), out_user[1:0], out_user[2]));
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want.value || out_user[1:0] !== want.status ||
            out_user[2] !== want.odd) begin
          flag_error($sformatf(
            "transfer %0d: expected value %0d status %0d from_odd %0b, got %0d %0d %0b",
            results_seen, want.value, want.status, want.odd,
            $signed(out_data), out_user[1:0], out_user[2]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule

@@ filelist.f @@
rtl/psds_pkg.sv
rtl/parity_split_dual_stack_unit.sv
tb/sv/tb.sv
